// ----- hw/rtl/spid_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spid_pkg
// Widths, types and register indices for the saturating PID step unit.
// ----------------------------------------------------------------------------
package spid_pkg;

  localparam int SAMPLE_W   = 24;              // Q16.8 sample
  localparam int GAIN_W     = 16;              // unsigned Q8.8 gain
  localparam int FRAC_W     = 8;
  localparam int LIMIT_W    = 25;              // unsigned Q17.8 bound
  localparam int DRIVE_W    = 26;              // signed Q.8 output
  localparam int ERR_W      = SAMPLE_W + 1;    // difference of two samples
  localparam int SUM_W      = 26;              // kept error sum
  localparam int NSUM_W     = SUM_W + 1;       // sum plus one error
  localparam int PROD_E_W   = GAIN_W + 1 + ERR_W;  // gain times error-sized value
  localparam int PROD_S_W   = GAIN_W + 1 + SUM_W;  // gain times sum
  localparam int TERM_W     = PROD_S_W - FRAC_W;   // widest shifted product
  localparam int TOTAL_W    = TERM_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LIMIT_W;

  localparam logic [GAIN_W-1:0]  KP_RST        = GAIN_W'(256);
  localparam logic [LIMIT_W-1:0] MAX_ERROR_RST = LIMIT_W'(65536 * 256);
  localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST = LIMIT_W'(65536 * 256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP            = 3'd0,
    CFG_KI            = 3'd1,
    CFG_KD            = 3'd2,
    CFG_MAX_ERROR     = 3'd3,
    CFG_MAX_SUM_ERROR = 3'd4,
    CFG_I_TERM_LIMIT  = 3'd5,
    CFG_OUT_LIMIT     = 3'd6
  } cfg_reg_e;

  typedef logic signed [TERM_W-1:0] term_t;

  // the three terms of one beat, between the term and output stages
  typedef struct packed {
    term_t p;
    term_t i;
    term_t d;
  } terms_t;

endpackage

// ----- hw/rtl/saturating_pid_step_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturating_pid_step_unit
// One step of a fixed-point PID controller with saturating P, clamped
// integral and clamped output, in a three-register elastic pipeline.
// ----------------------------------------------------------------------------
//  channel | signals                             | direction
//  --------+-------------------------------------+----------
//  in      | in_valid_i, in_stall_o, setpoint_i, | into block
//          | measured_i                          |
//  out     | out_valid_o, out_stall_i, drive_o   | out of block
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i   | into block
//
//  One beat per cycle while out_stall_i does not hold the pipeline; a beat
//  taken into the input register reaches drive_o through the term register,
//  then the output register.
//  The error sum and last measurement update as a beat leaves the input
//  register, so successive beats see each other's state with no gap.
//  Reset loads default gains and limits, clears the state and empties the
//  pipeline. out_stall_i backs up stage by stage; in_stall_o rises only
//  once all three registers hold beats.
// ----------------------------------------------------------------------------
module saturating_pid_step_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [spid_pkg::SAMPLE_W-1:0]   setpoint_i,
  input  logic signed [spid_pkg::SAMPLE_W-1:0]   measured_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [spid_pkg::DRIVE_W-1:0]    drive_o,
  input  logic                                   cfg_we_i,
  input  logic        [spid_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [spid_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import spid_pkg::*;

  // configuration
  logic [GAIN_W-1:0]  kp_q, ki_q, kd_q;
  logic [LIMIT_W-1:0] max_error_q, max_sum_error_q, i_term_limit_q, out_limit_q;

  // loop state
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic signed [SAMPLE_W-1:0] last_meas_q;

  // pipeline
  logic                       s1_valid_q, s2_valid_q, s3_valid_q;
  logic signed [SAMPLE_W-1:0] sp_q, mv_q;
  terms_t                     terms_q, terms_d;
  logic signed [DRIVE_W-1:0]  drive_q, drive_d;

  logic s1_adv, s2_adv, s2_ready, s3_ready, s1_ready, in_accept;

  assign s3_ready  = !s3_valid_q || !out_stall_i;
  assign s2_ready  = !s2_valid_q || s3_ready;
  assign s1_ready  = !s1_valid_q || s2_ready;
  assign s1_adv    = s1_valid_q && s2_ready;
  assign s2_adv    = s2_valid_q && s3_ready;
  assign in_accept = in_valid_i && s1_ready;

  assign in_stall_o  = !s1_ready;
  assign out_valid_o = s3_valid_q;
  assign drive_o     = drive_q;

  // ---------------- term stage ----------------
  logic signed [ERR_W-1:0]    err, dmeas;
  logic signed [NSUM_W-1:0]   err_x, nsum, me_x, ms_x;
  logic signed [PROD_E_W-1:0] p_prod, d_prod;
  logic signed [PROD_S_W-1:0] i_prod;
  term_t                      ol_t, itl_t;

  always_comb begin
    err    = $signed({sp_q[SAMPLE_W-1], sp_q}) - $signed({mv_q[SAMPLE_W-1], mv_q});
    dmeas  = $signed({last_meas_q[SAMPLE_W-1], last_meas_q})
           - $signed({mv_q[SAMPLE_W-1], mv_q});
    err_x  = $signed({{(NSUM_W-ERR_W){err[ERR_W-1]}}, err});
    me_x   = $signed({{(NSUM_W-LIMIT_W){1'b0}}, max_error_q});
    ms_x   = $signed({{(NSUM_W-LIMIT_W){1'b0}}, max_sum_error_q});
    nsum   = $signed({sum_q[SUM_W-1], sum_q}) + err_x;
    ol_t   = $signed({{(TERM_W-LIMIT_W){1'b0}}, out_limit_q});
    itl_t  = $signed({{(TERM_W-LIMIT_W){1'b0}}, i_term_limit_q});

    p_prod = $signed({1'b0, kp_q}) * err;
    i_prod = $signed({1'b0, ki_q}) * sum_q;
    d_prod = $signed({1'b0, kd_q}) * dmeas;

    if (err_x > me_x) begin
      terms_d.p = ol_t;
    end else if (err_x < -me_x) begin
      terms_d.p = -ol_t;
    end else begin
      terms_d.p = TERM_W'(p_prod >>> FRAC_W);
    end

    // integral product uses the sum from before this beat; the clamp checks the sum with this beat's error
    if (nsum > ms_x) begin
      terms_d.i = itl_t;
      sum_d     = SUM_W'(ms_x);
    end else if (nsum < -ms_x) begin
      terms_d.i = -itl_t;
      sum_d     = SUM_W'(-ms_x);
    end else begin
      terms_d.i = TERM_W'(i_prod >>> FRAC_W);
      sum_d     = SUM_W'(nsum);
    end

    terms_d.d = TERM_W'(d_prod >>> FRAC_W);
  end

  // ---------------- output stage ----------------
  logic signed [TOTAL_W-1:0] total, ol_x;

  always_comb begin
    total = $signed({{2{terms_q.p[TERM_W-1]}}, terms_q.p})
          + $signed({{2{terms_q.i[TERM_W-1]}}, terms_q.i})
          + $signed({{2{terms_q.d[TERM_W-1]}}, terms_q.d});
    ol_x  = $signed({{(TOTAL_W-LIMIT_W){1'b0}}, out_limit_q});
    if (total > ol_x) begin
      drive_d = DRIVE_W'(ol_x);
    end else if (total < -ol_x) begin
      drive_d = DRIVE_W'(-ol_x);
    end else begin
      drive_d = DRIVE_W'(total);
    end
  end

  // ---------------- control and state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q            <= KP_RST;
      ki_q            <= '0;
      kd_q            <= '0;
      max_error_q     <= MAX_ERROR_RST;
      max_sum_error_q <= '0;
      i_term_limit_q  <= '0;
      out_limit_q     <= OUT_LIMIT_RST;
      sum_q           <= '0;
      last_meas_q     <= '0;
      s1_valid_q      <= 1'b0;
      s2_valid_q      <= 1'b0;
      s3_valid_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_KP:            kp_q            <= cfg_data_i[GAIN_W-1:0];
          CFG_KI:            ki_q            <= cfg_data_i[GAIN_W-1:0];
          CFG_KD:            kd_q            <= cfg_data_i[GAIN_W-1:0];
          CFG_MAX_ERROR:     max_error_q     <= cfg_data_i;
          CFG_MAX_SUM_ERROR: max_sum_error_q <= cfg_data_i;
          CFG_I_TERM_LIMIT:  i_term_limit_q  <= cfg_data_i;
          CFG_OUT_LIMIT:     out_limit_q     <= cfg_data_i;
          default: ;
        endcase
      end
      if (s1_adv) begin
        sum_q       <= sum_d;
        last_meas_q <= mv_q;
      end
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sp_q <= setpoint_i;
      mv_q <= measured_i;
    end
    if (s1_adv) begin
      terms_q <= terms_d;
    end
    if (s2_adv) begin
      drive_q <= drive_d;
    end
  end

`ifndef SYNTHESIS
  // the sum is only ever clamped to a 25-bit bound, so it never reaches -2^25
  a_sum_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q != $signed({1'b1, {(SUM_W-1){1'b0}}}))
    else $error("error sum out of range");

  // loop state moves only when a beat leaves the input register
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(sum_q) && $stable(last_meas_q))
    else $error("loop state changed without a beat");

  // input only stalls with every stage occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s2_valid_q && s3_valid_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // a held term beat is not lost
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !s3_ready |=> s2_valid_q && $stable(terms_q))
    else $error("term stage dropped a beat");
`endif

endmodule
